// File: rtl/trv_pkg.sv
// Package for the Trivium keystream block: item types, register map,
// sequencer states and the single-round function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trv_pkg;

    // Sizes of the cipher
    localparam int unsigned TRV_STATE_BITS    = 288;
    localparam int unsigned TRV_KEY_BITS      = 80;
    localparam int unsigned TRV_IV_BASE       = 93;
    localparam int unsigned TRV_BYTE_BITS     = 8;
    localparam int unsigned TRV_WARMUP_ROUNDS = 4 * 288;

    // Configuration port
    localparam int unsigned TRV_DATA_W   = 64;
    localparam int unsigned TRV_ADDR_W   = 6;
    localparam int unsigned TRV_INDEX_W  = 3;
    localparam int unsigned TRV_DISC_W   = 3;
    localparam int unsigned TRV_HALF_W   = 16;

    localparam logic [TRV_INDEX_W-1:0] REG_KEY_LOW      = 3'd0;
    localparam logic [TRV_INDEX_W-1:0] REG_KEY_HIGH     = 3'd1;
    localparam logic [TRV_INDEX_W-1:0] REG_IV_LOW       = 3'd2;
    localparam logic [TRV_INDEX_W-1:0] REG_IV_HIGH      = 3'd3;
    localparam logic [TRV_INDEX_W-1:0] REG_DISCARD_BITS = 3'd4;

    localparam logic [TRV_DISC_W-1:0] DISCARD_RESET = 3'd1;

    // Input commands
    localparam logic CMD_INIT = 1'b0;
    localparam logic CMD_BYTE = 1'b1;

    typedef logic [TRV_STATE_BITS-1:0] trv_state_t;
    typedef logic [TRV_KEY_BITS-1:0]   trv_key_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_in;
    } trv_in_t;

    typedef struct packed {
        logic [7:0] keystream_byte;
        logic [7:0] data_out;
    } trv_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_PUSH
    } trv_fsm_t;

    // Keystream bit of the current state
    function automatic logic trv_z(input trv_state_t s);
        return s[65] ^ s[92] ^ s[161] ^ s[176] ^ s[242] ^ s[287];
    endfunction

    // One Trivium round: shift up by one, feed back at 0, 93 and 177
    function automatic trv_state_t trv_round(input trv_state_t s);
        logic       t1;
        logic       t2;
        logic       t3;
        trv_state_t n;
        t1 = s[65] ^ s[92] ^ (s[90] & s[91]) ^ s[170];
        t2 = s[161] ^ s[176] ^ (s[174] & s[175]) ^ s[263];
        t3 = s[242] ^ s[287] ^ (s[285] & s[286]) ^ s[68];
        n = {s[TRV_STATE_BITS-2:0], t3};
        n[93]  = t1;
        n[177] = t2;
        return n;
    endfunction

    // Load key and IV bit-reversed, set the top three bits
    function automatic trv_state_t trv_load(input trv_key_t k, input trv_key_t iv);
        trv_state_t n;
        n = '0;
        for (int i = 0; i < TRV_KEY_BITS; i++) begin
            n[i]               = k[TRV_KEY_BITS-1-i];
            n[TRV_IV_BASE + i] = iv[TRV_KEY_BITS-1-i];
        end
        n[285] = 1'b1;
        n[286] = 1'b1;
        n[287] = 1'b1;
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/trivium_keystream_cipher.sv
// Trivium keystream block, top level: APB register file, round sequencer
// and output register. Depends on trv_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Trivium (80-bit key, 80-bit IV) built around one round unit that advances
// the 288-bit state by one bit per cycle. An init item (command 0) loads key
// and IV from the registers, runs WARMUP_ROUNDS rounds plus discard_bits
// more, and returns an all-zero result. A byte item (command 1) runs eight
// rounds, one keystream bit each, first bit in the LSB, and returns the
// keystream byte and data_in XOR it. The round unit handles one item at a
// time; a finished result sits in the output register so a new item can be
// accepted while it waits. While an earlier result still waits there, the
// sequencer holds in hand-off until it is taken.
// Registers sit at byte addresses 0x00 key_low, 0x08 key_high, 0x10 iv_low,
// 0x18 iv_high, 0x20 discard_bits (reset 1); write them only while no item is
// in flight, since an init item samples them at acceptance.
module trivium_keystream_cipher
    import trv_pkg::*;
#(
    parameter int unsigned WARMUP_ROUNDS = TRV_WARMUP_ROUNDS
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    // input items
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  trv_in_t         s_payload,
    // result items
    output logic                  m_valid,
    input  wire                   m_ready,
    output trv_out_t              m_payload,
    // configuration
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [TRV_ADDR_W-1:0] paddr,
    input  wire  [TRV_DATA_W-1:0] pwdata,
    output logic [TRV_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned CNT_W = $clog2(WARMUP_ROUNDS + TRV_BYTE_BITS);

    logic [TRV_DATA_W-1:0] key_low_reg;
    logic [TRV_HALF_W-1:0] key_high_reg;
    logic [TRV_DATA_W-1:0] iv_low_reg;
    logic [TRV_HALF_W-1:0] iv_high_reg;
    logic [TRV_DISC_W-1:0] discard_reg;

    trv_state_t            cipher_reg;
    trv_state_t            cipher_next;
    trv_fsm_t              fsm_reg;
    trv_fsm_t              fsm_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [7:0]            ks_reg;
    logic [7:0]            ks_next;
    trv_in_t               item_reg;
    trv_in_t               item_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    trv_out_t              m_payload_reg;
    trv_out_t              m_payload_next;

    logic                  wr_en;
    logic [TRV_INDEX_W-1:0] reg_index;
    logic                  in_fire;
    logic                  out_free;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;
    assign reg_index = paddr[TRV_ADDR_W-1 -: TRV_INDEX_W];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            iv_low_reg   <= '0;
            iv_high_reg  <= '0;
            discard_reg  <= DISCARD_RESET;
        end else if (wr_en) begin
            case (reg_index)
                REG_KEY_LOW:      key_low_reg  <= pwdata;
                REG_KEY_HIGH:     key_high_reg <= pwdata[TRV_HALF_W-1:0];
                REG_IV_LOW:       iv_low_reg   <= pwdata;
                REG_IV_HIGH:      iv_high_reg  <= pwdata[TRV_HALF_W-1:0];
                REG_DISCARD_BITS: discard_reg  <= pwdata[TRV_DISC_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_index)
            REG_KEY_LOW:      prdata = key_low_reg;
            REG_KEY_HIGH:     prdata = {{(TRV_DATA_W-TRV_HALF_W){1'b0}}, key_high_reg};
            REG_IV_LOW:       prdata = iv_low_reg;
            REG_IV_HIGH:      prdata = {{(TRV_DATA_W-TRV_HALF_W){1'b0}}, iv_high_reg};
            REG_DISCARD_BITS: prdata = {{(TRV_DATA_W-TRV_DISC_W){1'b0}}, discard_reg};
            default:          prdata = '0;
        endcase
    end

    assign s_ready   = (fsm_reg == ST_IDLE);
    assign in_fire   = s_valid & s_ready;
    assign out_free  = ~m_valid_reg | m_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Sequencer state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            cipher_reg  <= '0;
        end else begin
            fsm_reg     <= fsm_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            cipher_reg  <= cipher_next;
        end
    end

    always_ff @(posedge aclk) begin
        ks_reg        <= ks_next;
        item_reg      <= item_next;
        m_payload_reg <= m_payload_next;
    end

    // Next state: load on accept, one round per cycle, then hand off the result
    always_comb begin
        fsm_next       = fsm_reg;
        cnt_next       = cnt_reg;
        cipher_next    = cipher_reg;
        ks_next        = ks_reg;
        item_next      = item_reg;
        m_payload_next = m_payload_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        case (fsm_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    item_next = s_payload;
                    fsm_next  = ST_RUN;
                    if (s_payload.command == CMD_BYTE) begin
                        cnt_next = CNT_W'(TRV_BYTE_BITS);
                    end else begin
                        cnt_next    = CNT_W'(WARMUP_ROUNDS) + CNT_W'(discard_reg);
                        cipher_next = trv_load({key_high_reg, key_low_reg},
                                               {iv_high_reg, iv_low_reg});
                    end
                end
            end
            ST_RUN: begin
                ks_next     = {trv_z(cipher_reg), ks_reg[7:1]};
                cipher_next = trv_round(cipher_reg);
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    fsm_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    fsm_next     = ST_IDLE;
                    if (item_reg.command == CMD_BYTE) begin
                        m_payload_next.keystream_byte = ks_reg;
                        m_payload_next.data_out       = ks_reg ^ item_reg.data_in;
                    end else begin
                        m_payload_next = '0;
                    end
                end
            end
            default: begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // An accepted item always starts a non-empty run
    a_start_run: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (fsm_reg == ST_RUN) && (cnt_reg != '0))
        else $error("accepted item did not start a run");

    // The last round leads to the hand-off state
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == ST_RUN) && (cnt_reg == CNT_W'(1)) |=> (fsm_reg == ST_PUSH))
        else $error("run did not end in hand-off");

    // A hand-off into a free output register presents a result next cycle
    a_push_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == ST_PUSH) && out_free |=> m_valid_reg && (fsm_reg == ST_IDLE))
        else $error("result not loaded on hand-off");

    // An init item yields an all-zero result
    a_init_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == ST_PUSH) && out_free && (item_reg.command == CMD_INIT)
        |=> (m_payload_reg == '0))
        else $error("init result not zero");
`endif

endmodule

`default_nettype wire
